// ===== rtl/bsmr_pkg.sv =====
// Shared constants and types for the byte stream modular reducer.
// No dependencies; every other file of the block imports this package.
package bsmr_pkg;

	localparam int LIMBS    = 4;
	localparam int LIMB_W   = 64;
	localparam int REM_W    = LIMBS * LIMB_W;
	localparam int BYTE_W   = 8;
	localparam int CFG_REGS = 4;
	localparam int CFG_IDX_W = (CFG_REGS > 1) ? $clog2(CFG_REGS) : 1;
	// result limbs on the output bus are fixed at CFG_REGS
	localparam int OUT_W    = CFG_REGS * LIMB_W;
	localparam int EXT_W    = (REM_W > OUT_W) ? REM_W : OUT_W;

	typedef logic [REM_W-1:0]  rem_t;
	typedef logic [OUT_W-1:0]  out_t;
	typedef logic [LIMB_W-1:0] limb_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

endpackage

// ===== rtl/bsmr_cfg_regs.sv =====
// Divisor register file, written through the configuration channel.
// Depends on bsmr_pkg.
module bsmr_cfg_regs
	import bsmr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_valid,
	input  cfg_idx_t cfg_index,
	input  limb_t    cfg_data,
	output logic     cfg_ready,
	output rem_t     divisor,
	output logic     divisor_zero
);

	limb_t div_q [LIMBS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LIMBS; i++) begin
				div_q[i] <= (i == 0) ? limb_t'(1) : '0;
			end
		end else if (cfg_valid) begin
			// indexes at or above LIMBS match no limb and are dropped
			for (int i = 0; i < LIMBS; i++) begin
				if (i < CFG_REGS && cfg_index == CFG_IDX_W'(i)) begin
					div_q[i] <= cfg_data;
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < LIMBS; i++) begin
			divisor[i*LIMB_W +: LIMB_W] = div_q[i];
		end
	end

	assign divisor_zero = (divisor == '0);

endmodule

// ===== rtl/bsmr_fold_byte.sv =====
// Folds one byte into the running remainder: eight shift-add and
// conditional-subtract steps, MSB first. Depends on bsmr_pkg.
module bsmr_fold_byte
	import bsmr_pkg::*;
(
	input  rem_t  rem_in,
	input  rem_t  divisor,
	input  byte_t data,
	output rem_t  rem_out
);

	function automatic rem_t fold_bit(input rem_t r, input rem_t d, input logic b);
		logic          carry;
		rem_t          dbl;
		logic [REM_W:0] diff;
		begin
			carry = r[REM_W-1];
			dbl   = {r[REM_W-2:0], b};
			diff  = {1'b0, dbl} - {1'b0, d};
			// subtract when the doubled value, carry included, reaches d
			fold_bit = (carry || !diff[REM_W]) ? diff[REM_W-1:0] : dbl;
		end
	endfunction

	always_comb begin
		rem_out = rem_in;
		for (int b = BYTE_W - 1; b >= 0; b--) begin
			rem_out = fold_bit(rem_out, divisor, data[b]);
		end
	end

endmodule

// ===== rtl/bsmr_out_stage.sv =====
// Result register on the master side; holds one result until transfer.
// Depends on bsmr_pkg.
module bsmr_out_stage
	import bsmr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  out_t load_data,
	input  logic load_zero,
	output logic free,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output out_t m_axis_tdata,
	output logic m_axis_tuser
);

	logic out_valid_q;
	out_t out_data_q;
	logic out_zero_q;

	assign free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (free) begin
			out_valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			out_data_q <= load_data;
			out_zero_q <= load_zero;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_zero_q;

endmodule

// ===== rtl/byte_stream_mod_reduce_256.sv =====
// Top level of the byte stream modular reducer: input register, running
// remainder, byte fold and result stage. Depends on bsmr_pkg, bsmr_cfg_regs,
// bsmr_fold_byte and bsmr_out_stage.
//
//  channel   direction  transfer on             payload
//  s_axis    in         tvalid & tready         tdata = data_byte, tlast = last_byte
//  m_axis    out        tvalid & tready         tdata = remainder limbs 0..3, tuser = zero_modulus
//  cfg       in         cfg_valid & cfg_ready   cfg_index = limb, cfg_data = value
//
// One byte per cycle, unless a last byte waits on the result register. An
// accepted byte is held in the input register, and all eight bit steps fold
// it into the remainder from there; a last byte writes the folded value into
// the result register once that is free. Only a last byte waits on a full
// result register. Reset clears the remainder and sets the divisor to one;
// no clearing pass.
module byte_stream_mod_reduce_256
	import bsmr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_axis_tvalid,
	output logic     s_axis_tready,
	input  byte_t    s_axis_tdata,   // [7:0] data_byte
	input  logic     s_axis_tlast,
	output logic     m_axis_tvalid,
	input  logic     m_axis_tready,
	output out_t     m_axis_tdata,   // limb0 [63:0], limb1, limb2, limb3 [255:192]
	output logic     m_axis_tuser,   // [0] zero_modulus
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  cfg_idx_t cfg_index,
	input  limb_t    cfg_data
);

	logic  valid_s1;
	byte_t byte_s1;
	logic  last_s1;
	rem_t  rem_q;

	rem_t  divisor;
	logic  divisor_zero;
	rem_t  rem_next;
	logic  out_free;
	logic  advance;
	logic  [EXT_W-1:0] rem_ext;
	out_t  res_data;

	bsmr_cfg_regs u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cfg_ready    (cfg_ready),
		.divisor      (divisor),
		.divisor_zero (divisor_zero)
	);

	bsmr_fold_byte u_fold (
		.rem_in  (rem_q),
		.divisor (divisor),
		.data    (byte_s1),
		.rem_out (rem_next)
	);

	// a byte without the last mark never waits on the output side
	assign advance       = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			rem_q    <= '0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				rem_q <= last_s1 ? '0 : rem_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	assign rem_ext  = EXT_W'(rem_next);
	assign res_data = divisor_zero ? '0 : rem_ext[OUT_W-1:0];

	bsmr_out_stage u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (advance && last_s1),
		.load_data     (res_data),
		.load_zero     (divisor_zero),
		.free          (out_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

// ===== tb/sv/byte_stream_mod_reduce_256_test.sv =====
// Self-checking bench for byte_stream_mod_reduce_256: byte strings reduced mod a 256-bit divisor.
// A bit-serial remainder shadow predicts each result not typed in; depends on bsmr_pkg and the RTL.
module byte_stream_mod_reduce_256_test;
	import bsmr_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int PHASE_ITEMS    = 83;
	localparam int PHASES         = 9;
	localparam int PLAN_LEN       = 29;

	localparam cfg_idx_t DIV_LIMB0 = cfg_idx_t'(0);
	localparam cfg_idx_t DIV_LIMB1 = cfg_idx_t'(1);
	localparam cfg_idx_t DIV_LIMB2 = cfg_idx_t'(2);
	localparam cfg_idx_t DIV_LIMB3 = cfg_idx_t'(3);

	localparam int MOD_TOP_SET = 0;	// full width, top bit set: overflow on doubling
	localparam int MOD_SHORT   = 1;	// small divisor in limb 0
	localparam int MOD_MIXED   = 2;	// each limb zero, all ones or random

	typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t kind;
		cfg_idx_t  idx;
		limb_t     value;
		byte_t     data;
		logic      last;
		logic      known;
		out_t      rem;
		logic      zero;
	} plan_row_t;

	typedef struct {
		out_t rem;
		logic zero;
	} mod_result_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     s_axis_tvalid = 1'b0;
	logic     s_axis_tready;
	byte_t    s_axis_tdata = '0;
	logic     s_axis_tlast = 1'b0;
	logic     m_axis_tvalid;
	logic     m_axis_tready = 1'b0;
	out_t     m_axis_tdata;
	logic     m_axis_tuser;
	logic     cfg_valid = 1'b0;
	logic     cfg_ready;
	cfg_idx_t cfg_index = '0;
	limb_t    cfg_data = '0;

	// typed-in expectation that travels with the byte being offered
	logic item_known = 1'b0;
	out_t item_rem = '0;
	logic item_zero = 1'b0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int n_errors = 0;
	int n_bytes = 0;
	int n_checked = 0;
	int n_settings = 0;
	int quiet_cycles = 0;

	rem_t        residue = '0;
	rem_t        modulus = rem_t'(1);
	mod_result_t remainders_due[$];
	plan_row_t   plan [PLAN_LEN];

	byte_stream_mod_reduce_256 u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Shift in the byte msb first; one conditional subtract per bit.
	task automatic fold_byte(input byte_t b, input logic is_last, input logic known,
			input out_t k_rem, input logic k_zero);
		logic [REM_W:0] acc;
		mod_result_t    r;
		int             i;
		for (i = BYTE_W - 1; i >= 0; i--) begin
			acc = {residue, b[i]};
			if (acc >= {1'b0, modulus})
				acc = acc - {1'b0, modulus};
			residue = acc[REM_W-1:0];
		end
		if (is_last) begin
			r.zero = (modulus == '0);
			r.rem = '0;
			for (i = 0; i < CFG_REGS; i++) begin
				if (i < LIMBS && !r.zero)
					r.rem[i*LIMB_W +: LIMB_W] = residue[i*LIMB_W +: LIMB_W];
			end
			if (known) begin
				r.rem = k_rem;
				r.zero = k_zero;
			end
			remainders_due.push_back(r);
			residue = '0;
		end
	endtask

	always @(posedge clk) begin
		mod_result_t want;
		int          j;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (remainders_due.size() == 0) begin
					$error("remainder transfer with no string pending");
					n_errors++;
				end else begin
					want = remainders_due.pop_front();
					for (j = 0; j < CFG_REGS; j++) begin
						if (m_axis_tdata[j*LIMB_W +: LIMB_W] !== want.rem[j*LIMB_W +: LIMB_W]) begin
							$error("remainder_limb%0d: expected %h, actual %h", j,
								want.rem[j*LIMB_W +: LIMB_W], m_axis_tdata[j*LIMB_W +: LIMB_W]);
							n_errors++;
						end
					end
					if (m_axis_tuser !== want.zero) begin
						$error("zero_modulus: expected %b, actual %b", want.zero, m_axis_tuser);
						n_errors++;
					end
					n_checked++;
				end
			end
			if (cfg_valid && cfg_ready && int'(cfg_index) < LIMBS)
				modulus[int'(cfg_index)*LIMB_W +: LIMB_W] = cfg_data;
			if (s_axis_tvalid && s_axis_tready) begin
				fold_byte(s_axis_tdata, s_axis_tlast, item_known, item_rem, item_zero);
				n_bytes++;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("byte_stream_mod_reduce_256 verification failed");
			$finish;
		end
	end

	task automatic send_byte(input byte_t b, input logic is_last, input logic known,
			input out_t k_rem, input logic k_zero);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= is_last;
		item_known <= known;
		item_rem <= k_rem;
		item_zero <= k_zero;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Hold off the sender until every remainder is back and the fold has settled.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (remainders_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// cfg_valid stays high; the caller drops it after the last write of a group
	task automatic write_limb(input cfg_idx_t idx, input limb_t value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_modulus(input rem_t m);
		int i;
		drain();
		for (i = 0; i < CFG_REGS; i++)
			write_limb(cfg_idx_t'(i), m[i*LIMB_W +: LIMB_W]);
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	function automatic limb_t rand_limb();
		case ($urandom_range(3))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic rem_t rand_modulus(input int style);
		rem_t m;
		int   i;
		m = '0;
		case (style)
			MOD_TOP_SET: begin
				for (i = 0; i < LIMBS; i++)
					m[i*LIMB_W +: LIMB_W] = {$urandom, $urandom};
				m[REM_W-1] = 1'b1;
			end
			MOD_SHORT: m = rem_t'($urandom_range(1000000, 2));
			default: begin
				for (i = 0; i < LIMBS; i++)
					m[i*LIMB_W +: LIMB_W] = rand_limb();
			end
		endcase
		return m;
	endfunction

	function automatic byte_t rand_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return byte_t'($urandom);
		endcase
	endfunction

	// mostly short strings, now and then a long one that wraps past 256 bits
	task automatic run_strings(input int quota);
		int sent;
		int len;
		int k;
		sent = 0;
		while (sent < quota) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(64, 33) : $urandom_range(12, 1);
			for (k = 0; k < len; k++)
				send_byte(rand_byte(), k == len - 1, 1'b0, '0, 1'b0);
			sent += len;
		end
	endtask

	function automatic plan_row_t cfg_row(input cfg_idx_t idx, input limb_t value);
		plan_row_t r;
		r = '{ROW_CFG, idx, value, '0, 1'b0, 1'b0, '0, 1'b0};
		return r;
	endfunction

	function automatic plan_row_t byte_row(input byte_t data, input logic last);
		plan_row_t r;
		r = '{ROW_BYTE, DIV_LIMB0, '0, data, last, 1'b0, '0, 1'b0};
		return r;
	endfunction

	function automatic plan_row_t known_row(input byte_t data, input logic last,
			input out_t rem, input logic zero);
		plan_row_t r;
		r = '{ROW_BYTE, DIV_LIMB0, '0, data, last, 1'b1, rem, zero};
		return r;
	endfunction

	initial begin
		int r;
		int p;
		plan = '{
			// divisor one out of reset: everything reduces to zero
			known_row(8'hFF, 1'b1, '0, 1'b0),
			known_row(8'h00, 1'b1, '0, 1'b0),
			// zero divisor: flagged, remainder forced to zero
			cfg_row(DIV_LIMB0, '0), cfg_row(DIV_LIMB1, '0),
			cfg_row(DIV_LIMB2, '0), cfg_row(DIV_LIMB3, '0),
			byte_row(8'hA5, 1'b0),
			known_row(8'hFF, 1'b1, '0, 1'b1),
			// all-ones divisor
			cfg_row(DIV_LIMB0, '1), cfg_row(DIV_LIMB1, '1),
			cfg_row(DIV_LIMB2, '1), cfg_row(DIV_LIMB3, '1),
			known_row(8'h00, 1'b1, '0, 1'b0),
			known_row(8'hFF, 1'b1, out_t'(8'hFF), 1'b0),
			// 2^255 + 1
			cfg_row(DIV_LIMB0, 64'd1), cfg_row(DIV_LIMB1, '0),
			cfg_row(DIV_LIMB2, '0), cfg_row(DIV_LIMB3, 64'h8000_0000_0000_0000),
			byte_row(8'hFF, 1'b0), byte_row(8'h7F, 1'b0), byte_row(8'h01, 1'b1),
			// divisor swapped in the middle of a string
			cfg_row(DIV_LIMB0, 64'd251), cfg_row(DIV_LIMB1, '0),
			cfg_row(DIV_LIMB2, '0), cfg_row(DIV_LIMB3, '0),
			byte_row(8'hDE, 1'b0), byte_row(8'hAD, 1'b0),
			cfg_row(DIV_LIMB0, 64'h1_0001),
			byte_row(8'hBE, 1'b1)
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 22;
		recv_idle_pct = 83;
		for (r = 0; r < PLAN_LEN; r++) begin
			if (plan[r].kind == ROW_CFG) begin
				if (r == 0 || plan[r-1].kind == ROW_BYTE)
					drain();
				write_limb(plan[r].idx, plan[r].value);
				if (r == PLAN_LEN - 1 || plan[r+1].kind != ROW_CFG) begin
					cfg_valid <= 1'b0;
					n_settings++;
				end
			end else begin
				send_byte(plan[r].data, plan[r].last, plan[r].known, plan[r].rem, plan[r].zero);
			end
		end

		for (p = 0; p < PHASES; p++) begin
			case (p / 3)
				0: begin
					send_idle_pct = 22;
					recv_idle_pct = 83;
				end
				1: begin
					send_idle_pct = 83;
					recv_idle_pct = 22;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			load_modulus(rand_modulus(p % 3));
			run_strings(PHASE_ITEMS);
		end

		drain();
		if (remainders_due.size() != 0) begin
			$error("%0d remainders never arrived", remainders_due.size());
			n_errors++;
		end

		$display("%0d bytes folded, %0d remainders compared, %0d divisor settings loaded",
			n_bytes, n_checked, n_settings);
		$display("zero, all-ones, top-bit and mid-string divisors; stalls on either side and none");
		if (n_errors == 0)
			$display("byte_stream_mod_reduce_256 verification clean");
		else
			$display("byte_stream_mod_reduce_256 verification failed");
		$finish;
	end

endmodule
